// ===== rtl/piecewise_linear_level_sensor_defines.svh =====
// assertion macros for the piecewise linear level sensor
`ifndef PIECEWISE_LINEAR_LEVEL_SENSOR_DEFINES_SVH
`define PIECEWISE_LINEAR_LEVEL_SENSOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked at every clock edge out of reset
`define PLLS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("level sensor check failed");

// next-cycle implication, checked at every clock edge out of reset
`define PLLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("level sensor check failed");

`else

`define PLLS_ASSERT_NOW(label, ante, cons)
`define PLLS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/plls_pkg.sv =====
// shared constants, types and helpers of the piecewise linear level sensor
package plls_pkg;

    // defaults of the top level parameters
    localparam int DEF_POINTS    = 8;
    localparam int DEF_BOTTOM_MM = 400;
    localparam int DEF_ADC_BITS  = 10;

    // converter full scale in millivolts
    localparam int FULL_SCALE_MV = 3250;

    // register file layout
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 28;
    localparam int ADDR_W    = 3;
    localparam int MV_W      = 12;
    localparam int H_W       = 16;
    localparam int SEG_W     = 4;
    localparam int LEVEL_W   = 9;
    localparam int LEVEL_MAX = 511;

    // divider layout: quotient bits and restoring steps per pipeline stage
    localparam int Q_W            = 16;
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES     = Q_W / STEPS_PER_STAGE;
    localparam int MAG_W          = Q_W + MV_W;

    // calibration points after reset: millivolts in the top field, height below
    localparam logic [REG_W-1:0] RESET_POINTS [NUM_REGS] = '{
        28'd35389740,  28'd39321850,  28'd49807560,  28'd62914710,
        28'd85852260,  28'd155975730, 28'd186777640, 28'd201850915
    };

    // item in flight through the divider stages
    typedef struct packed {
        logic [MV_W-1:0]  rem;
        logic [Q_W-1:0]   qn;
        logic [MV_W-1:0]  den;
        logic             neg;
        logic [H_W-1:0]   y1;
        logic [SEG_W-1:0] seg;
        logic [MV_W-1:0]  mv;
    } div_item_t;

    // one restoring step: shift in a dividend bit, subtract when it fits
    function automatic logic [MV_W:0] div_step(
        input logic [MV_W-1:0] rem,
        input logic            nbit,
        input logic [MV_W-1:0] den
    );
        logic [MV_W:0] wide;
        logic [MV_W:0] diff;
        wide = {rem, nbit};
        diff = wide - {1'b0, den};
        if (wide >= {1'b0, den})
        begin
            return {1'b1, diff[MV_W-1:0]};
        end
        return {1'b0, wide[MV_W-1:0]};
    endfunction

endpackage

// ===== rtl/piecewise_linear_level_sensor.sv =====
// top level of the piecewise linear level sensor: millivolt scaling and calibration
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_ready  | adc_code
//  output   | out_valid / out_ready| level_mm, voltage_mv, segment
//  config   | cfg_we               | cfg_addr, cfg_data
//
// one code per cycle sustained while the output does not stall; the 16-bit
// restoring divider works at four quotient bits per stage.
// rst_n clears all valid bits and loads the reset calibration points.
// a stall at the output freezes every stage at once; in_ready follows
// the output register being empty or taken in the same cycle.
`include "piecewise_linear_level_sensor_defines.svh"

module piecewise_linear_level_sensor #(
    parameter int POINTS    = plls_pkg::DEF_POINTS,
    parameter int BOTTOM_MM = plls_pkg::DEF_BOTTOM_MM,
    parameter int ADC_BITS  = plls_pkg::DEF_ADC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ADC_BITS-1:0]                adc_code,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [plls_pkg::LEVEL_W-1:0]       level_mm,
    output logic [plls_pkg::MV_W-1:0]          voltage_mv,
    output logic [plls_pkg::SEG_W-1:0]         segment,
    input  logic                               cfg_we,
    input  logic [plls_pkg::ADDR_W-1:0]        cfg_addr,
    input  logic [plls_pkg::REG_W-1:0]         cfg_data
);

    localparam int MV_W   = plls_pkg::MV_W;
    localparam int H_W    = plls_pkg::H_W;
    localparam int SEG_W  = plls_pkg::SEG_W;
    localparam int Q_W    = plls_pkg::Q_W;
    localparam int MAG_W  = plls_pkg::MAG_W;
    localparam int DS     = plls_pkg::DIV_STAGES;
    localparam int STEPS  = plls_pkg::STEPS_PER_STAGE;
    localparam int PROD_W = ADC_BITS + MV_W;
    localparam int NSTAGE = DS + 4;
    localparam int LVL_W  = H_W + 2;

    localparam logic signed [LVL_W-1:0] BOTTOM  = LVL_W'(BOTTOM_MM);
    localparam logic signed [LVL_W-1:0] LVL_TOP = LVL_W'(plls_pkg::LEVEL_MAX);

    // calibration registers
    logic [plls_pkg::REG_W-1:0] point_reg [plls_pkg::NUM_REGS];

    // pipeline control
    logic              adv;
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;

    // stage 1: millivolts
    logic [PROD_W-1:0] prod;
    logic [MV_W-1:0]   mv_next;
    logic [MV_W-1:0]   mv_reg;

    // stage 2: segment choice and differences
    logic [SEG_W-1:0]  seg_next,  sel_seg_reg;
    logic [MV_W-1:0]   dx_next,   sel_dx_reg;
    logic [MV_W-1:0]   den_next,  sel_den_reg;
    logic [H_W-1:0]    y1_next,   sel_y1_reg;
    logic [H_W-1:0]    dy_next,   sel_dy_reg;
    logic              neg_next,  sel_neg_reg;
    logic [MV_W-1:0]   sel_mv_reg;

    // stage 3 and divider stages
    logic [MAG_W-1:0]      mag;
    plls_pkg::div_item_t   div_reg  [DS+1];
    plls_pkg::div_item_t   div_next [DS+1];

    // output stage
    logic [LVL_W-1:0]         h_sum;
    logic signed [LVL_W-1:0]  lvl_raw;
    logic [plls_pkg::LEVEL_W-1:0] level_next, level_reg;
    logic [MV_W-1:0]          vout_reg;
    logic [SEG_W-1:0]         segout_reg;

    // the whole pipeline moves when the output register can take an item
    assign adv        = out_ready || !valid_reg[NSTAGE-1];
    assign in_ready   = adv;
    assign valid_next = {valid_reg[NSTAGE-2:0], in_valid};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < plls_pkg::NUM_REGS; k++)
            begin
                point_reg[k] <= plls_pkg::RESET_POINTS[k];
            end
        end
        else if (cfg_we)
        begin
            point_reg[cfg_addr] <= cfg_data;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // code to millivolts
    always_comb
    begin
        prod    = PROD_W'(adc_code) * PROD_W'(plls_pkg::FULL_SCALE_MV);
        mv_next = MV_W'(prod >> ADC_BITS);
    end

    // pick the segment and form its differences
    always_comb
    begin
        logic          found;
        logic [H_W:0]  dy_wide;
        logic [MV_W-1:0] x1;
        logic [H_W-1:0]  y2;
        found    = 1'b0;
        seg_next = SEG_W'(POINTS);
        x1       = mv_reg;
        y1_next  = point_reg[POINTS-1][H_W-1:0];
        y2       = point_reg[POINTS-1][H_W-1:0];
        den_next = MV_W'(1);
        dx_next  = '0;
        if (mv_reg <= point_reg[0][H_W +: MV_W])
        begin
            seg_next = '0;
            y1_next  = point_reg[0][H_W-1:0];
            y2       = point_reg[0][H_W-1:0];
        end
        else
        begin
            for (int i = 1; i < POINTS; i++)
            begin
                if (!found && mv_reg <= point_reg[i][H_W +: MV_W])
                begin
                    found    = 1'b1;
                    seg_next = SEG_W'(i);
                    x1       = point_reg[i-1][H_W +: MV_W];
                    y1_next  = point_reg[i-1][H_W-1:0];
                    y2       = point_reg[i][H_W-1:0];
                    den_next = point_reg[i][H_W +: MV_W] - point_reg[i-1][H_W +: MV_W];
                end
            end
            if (found)
            begin
                dx_next = mv_reg - x1;
            end
        end
        dy_wide  = {1'b0, y2} - {1'b0, y1_next};
        neg_next = dy_wide[H_W];
        dy_next  = neg_next ? H_W'(-dy_wide) : dy_wide[H_W-1:0];
    end

    // product magnitude; its top bits are always below the divisor
    assign mag = MAG_W'(sel_dy_reg) * MAG_W'(sel_dx_reg);

    // divider stages, STEPS_PER_STAGE restoring steps each
    always_comb
    begin
        plls_pkg::div_item_t d;
        logic [MV_W:0]       st;
        div_next[0].rem = mag[MAG_W-1:Q_W];
        div_next[0].qn  = mag[Q_W-1:0];
        div_next[0].den = sel_den_reg;
        div_next[0].neg = sel_neg_reg;
        div_next[0].y1  = sel_y1_reg;
        div_next[0].seg = sel_seg_reg;
        div_next[0].mv  = sel_mv_reg;
        for (int k = 1; k <= DS; k++)
        begin
            d = div_reg[k-1];
            for (int s = 0; s < STEPS; s++)
            begin
                st    = plls_pkg::div_step(d.rem, d.qn[Q_W-1], d.den);
                d.rem = st[MV_W-1:0];
                d.qn  = {d.qn[Q_W-2:0], st[MV_W]};
            end
            div_next[k] = d;
        end
    end

    // height, level and saturation
    always_comb
    begin
        if (div_reg[DS].neg)
        begin
            h_sum = LVL_W'(div_reg[DS].y1) - LVL_W'(div_reg[DS].qn);
        end
        else
        begin
            h_sum = LVL_W'(div_reg[DS].y1) + LVL_W'(div_reg[DS].qn);
        end
        lvl_raw = BOTTOM - $signed(h_sum);
        if (lvl_raw < 0)
        begin
            level_next = '0;
        end
        else if (lvl_raw > LVL_TOP)
        begin
            level_next = plls_pkg::LEVEL_W'(plls_pkg::LEVEL_MAX);
        end
        else
        begin
            level_next = lvl_raw[plls_pkg::LEVEL_W-1:0];
        end
    end

    // payload registers, all stages advance together
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mv_reg      <= mv_next;
            sel_seg_reg <= seg_next;
            sel_mv_reg  <= mv_reg;
            sel_dx_reg  <= dx_next;
            sel_den_reg <= den_next;
            sel_y1_reg  <= y1_next;
            sel_dy_reg  <= dy_next;
            sel_neg_reg <= neg_next;
            for (int k = 0; k <= DS; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            level_reg  <= level_next;
            vout_reg   <= div_reg[DS].mv;
            segout_reg <= div_reg[DS].seg;
        end
    end

    assign out_valid  = valid_reg[NSTAGE-1];
    assign level_mm   = level_reg;
    assign voltage_mv = vout_reg;
    assign segment    = segout_reg;

    // checks
    `PLLS_ASSERT_NEXT(a_stall_freezes, !in_ready, $stable(valid_reg))
    `PLLS_ASSERT_NOW(a_seg_range, out_valid, segment <= SEG_W'(POINTS))
    `PLLS_ASSERT_NOW(a_rem_below_den, valid_reg[NSTAGE-2], div_reg[DS].rem < div_reg[DS].den)
    `PLLS_ASSERT_NOW(a_level_bound, out_valid && (BOTTOM_MM <= plls_pkg::LEVEL_MAX),
        LVL_W'(level_mm) <= LVL_W'(BOTTOM_MM))

endmodule

// ===== bench/piecewise_linear_level_sensor_tb.sv =====
// testbench for the piecewise linear level sensor: random codes and tables against a predictor
module piecewise_linear_level_sensor_tb;

    localparam int ADC_W         = 10;
    localparam int POINT_COUNT   = 8;
    localparam int BOTTOM_DIST   = 400;
    localparam int MV_TOP        = 3250;
    localparam int HEIGHT_TOP    = 65535;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic [plls_pkg::REG_W-1:0] POINT_FULL = 28'd213057535;
    localparam logic [plls_pkg::REG_W-1:0] DEFAULT_TABLE [POINT_COUNT] = '{
        28'd35389740,  28'd39321850,  28'd49807560,  28'd62914710,
        28'd85852260,  28'd155975730, 28'd186777640, 28'd201850915
    };

    typedef enum {TABLE_ZERO, TABLE_FULL, TABLE_RISING, TABLE_SCRAMBLED} table_kind_t;

    // one output reading as the block presents it
    typedef struct packed {
        logic [plls_pkg::LEVEL_W-1:0] level;
        logic [plls_pkg::MV_W-1:0]    mv;
        logic [plls_pkg::SEG_W-1:0]   seg;
    } level_reading_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [ADC_W-1:0]               adc_code = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [plls_pkg::LEVEL_W-1:0]   level_mm;
    logic [plls_pkg::MV_W-1:0]      voltage_mv;
    logic [plls_pkg::SEG_W-1:0]     segment;
    logic                           cfg_we = 1'b0;
    logic [plls_pkg::ADDR_W-1:0]    cfg_addr = '0;
    logic [plls_pkg::REG_W-1:0]     cfg_data = '0;

    logic [plls_pkg::REG_W-1:0] cal_table [POINT_COUNT];
    logic [plls_pkg::REG_W-1:0] table_next [POINT_COUNT];
    logic [ADC_W-1:0]           pending_codes [$];
    level_reading_t             expected_readings [$];
    level_reading_t             oldest_reading;

    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    bit hold_request = 1'b0;
    int tx_gap = 0;
    int rx_stall = 0;
    int fail_count = 0;
    int cycle_count = 0;

    piecewise_linear_level_sensor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_code   (adc_code),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .level_mm   (level_mm),
        .voltage_mv (voltage_mv),
        .segment    (segment),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data)
    );

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // converter code to truncated millivolts
    function automatic int code_to_mv(input int code);
        return (code * plls_pkg::FULL_SCALE_MV) >> ADC_W;
    endfunction

    // smallest code whose millivolts reach the target, 1024 when none does
    function automatic int first_code_reaching(input int target);
        int c;
        c = 0;
        while (c < (1 << ADC_W) && code_to_mv(c) < target)
            c++;
        return c;
    endfunction

    // expected reading for one code under the current calibration table
    function automatic level_reading_t predict_reading(input logic [ADC_W-1:0] code);
        longint mv;
        longint x1;
        longint x2;
        longint y1;
        longint y2;
        longint den;
        longint h;
        longint lvl;
        int     i;
        int     seg_n;
        bit     found;
        level_reading_t r;
        mv = code_to_mv(int'(code));
        x1 = cal_table[0][plls_pkg::REG_W-1:plls_pkg::H_W];
        found = 1'b0;
        if (mv <= x1)
        begin
            h = cal_table[0][plls_pkg::H_W-1:0];
            seg_n = 0;
        end
        else
        begin
            // above the last point unless a segment takes it
            h = cal_table[POINT_COUNT-1][plls_pkg::H_W-1:0];
            seg_n = POINT_COUNT;
            for (i = 1; i < POINT_COUNT; i++)
            begin
                x2 = cal_table[i][plls_pkg::REG_W-1:plls_pkg::H_W];
                if (!found && mv <= x2)
                begin
                    x1 = cal_table[i-1][plls_pkg::REG_W-1:plls_pkg::H_W];
                    y1 = cal_table[i-1][plls_pkg::H_W-1:0];
                    y2 = cal_table[i][plls_pkg::H_W-1:0];
                    den = x2 - x1;
                    h = y1;
                    if (den != 0)
                        h = y1 + ((y2 - y1) * (mv - x1)) / den;
                    seg_n = i;
                    found = 1'b1;
                end
            end
        end
        // saturate the level to the output range
        lvl = BOTTOM_DIST - h;
        if (lvl < 0)
            lvl = 0;
        if (lvl > plls_pkg::LEVEL_MAX)
            lvl = plls_pkg::LEVEL_MAX;
        r.level = lvl[plls_pkg::LEVEL_W-1:0];
        r.mv    = mv[plls_pkg::MV_W-1:0];
        r.seg   = seg_n[plls_pkg::SEG_W-1:0];
        return r;
    endfunction

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // input driver: offers queued codes, records the expectation of each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            adc_code <= '0;
            tx_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_readings.push_back(predict_reading(adc_code));
            // next code once the current one is gone
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_codes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    adc_code <= pending_codes.pop_front();
                    if (tx_idle)
                        tx_gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor: checks each transfer, stalls the receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected reading, expected none, actual %0d %0d %0d",
                             $time, level_mm, voltage_mv, segment);
                    fail_count++;
                end
                else
                begin
                    oldest_reading = expected_readings.pop_front();
                    report_field("level_mm", oldest_reading.level, level_mm);
                    report_field("voltage_mv", oldest_reading.mv, voltage_mv);
                    report_field("segment", oldest_reading.seg, segment);
                end
            end
            // long hold on request, otherwise random stalls
            if (hold_request)
            begin
                hold_request = 1'b0;
                rx_stall = LONG_HOLD;
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_idle && $urandom_range(0, 3) == 0)
                    rx_stall = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // wait until every code is sent and every reading is back, then let the pipe settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_codes.size() != 0 || in_valid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write the staged table into the block, one point per cycle
    task automatic load_table();
        int k;
        for (k = 0; k < POINT_COUNT; k++)
        begin
            @(posedge clk);
            cfg_we   <= 1'b1;
            cfg_addr <= k[plls_pkg::ADDR_W-1:0];
            cfg_data <= table_next[k];
            cal_table[k] = table_next[k];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // stage a calibration table of the given kind
    task automatic make_table(input table_kind_t kind);
        int  k;
        int  x;
        int  hgt;
        bit  in_range;
        x = $urandom_range(0, 600);
        hgt = $urandom_range(200, BOTTOM_DIST);
        in_range = $urandom_range(0, 1);
        for (k = 0; k < POINT_COUNT; k++)
        begin
            case (kind)
                TABLE_ZERO:
                    table_next[k] = '0;
                TABLE_FULL:
                    table_next[k] = POINT_FULL;
                TABLE_RISING:
                begin
                    table_next[k] = {x[plls_pkg::MV_W-1:0], hgt[plls_pkg::H_W-1:0]};
                    x = x + $urandom_range(0, 450);
                    if (x > MV_TOP)
                        x = MV_TOP;
                    if (in_range)
                        hgt = hgt - $urandom_range(0, hgt) / 3;
                    else
                        hgt = $urandom_range(0, HEIGHT_TOP);
                end
                default:
                begin
                    x = $urandom_range(0, MV_TOP);
                    hgt = in_range ? $urandom_range(0, BOTTOM_DIST) : $urandom_range(0, HEIGHT_TOP);
                    table_next[k] = {x[plls_pkg::MV_W-1:0], hgt[plls_pkg::H_W-1:0]};
                end
            endcase
        end
    endtask

    // random codes, a quarter of them at or next to a calibration voltage
    task automatic push_random(input int n);
        int j;
        int c;
        for (j = 0; j < n; j++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                c = first_code_reaching(
                        cal_table[$urandom_range(0, POINT_COUNT-1)][plls_pkg::REG_W-1:plls_pkg::H_W])
                    + $urandom_range(0, 2) - 1;
                if (c < 0)
                    c = 0;
                if (c > (1 << ADC_W) - 1)
                    c = (1 << ADC_W) - 1;
            end
            else
                c = $urandom_range(0, (1 << ADC_W) - 1);
            pending_codes.push_back(c[ADC_W-1:0]);
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        int k;
        int c;
        int p;
        for (k = 0; k < POINT_COUNT; k++)
            cal_table[k] = DEFAULT_TABLE[k];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: code extremes and both sides of every reset calibration voltage
        pending_codes.push_back(10'd0);
        pending_codes.push_back(10'd1023);
        pending_codes.push_back(10'd1);
        pending_codes.push_back(10'd512);
        pending_codes.push_back(10'h2AA);
        pending_codes.push_back(10'h155);
        for (k = 0; k < POINT_COUNT; k++)
        begin
            c = first_code_reaching(cal_table[k][plls_pkg::REG_W-1:plls_pkg::H_W]);
            if (c < (1 << ADC_W))
                pending_codes.push_back(c[ADC_W-1:0]);
            if (c > 0)
                pending_codes.push_back(ADC_W'(c - 1));
        end
        wait_drained();

        // reset table, random codes under random gaps and stalls, the first batch with a long receiver hold
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        push_random(125);
        hold_request = 1'b1;
        wait_drained();
        push_random(125);
        wait_drained();

        // extreme tables: all points zero, then all at the top of their range
        make_table(TABLE_ZERO);
        load_table();
        push_random(40);
        wait_drained();
        make_table(TABLE_FULL);
        load_table();
        push_random(40);
        wait_drained();

        // random rising and scrambled tables under varied idling
        for (p = 0; p < 6; p++)
        begin
            make_table(p % 2 == 0 ? TABLE_RISING : TABLE_SCRAMBLED);
            load_table();
            tx_idle = (p != 2) && (p != 5);
            rx_idle = (p != 2) && (p != 3);
            push_random(150);
            if (p == 4)
                hold_request = 1'b1;
            wait_drained();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/plls_pkg.sv
rtl/piecewise_linear_level_sensor.sv
bench/piecewise_linear_level_sensor_tb.sv
